/* sv/gbts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared codes and field widths for the gap buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 9;
  localparam int STAT_W = 2;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_DELETE = 2'd1;
  localparam kind_t KIND_MOVE   = 2'd2;
  localparam kind_t KIND_READ   = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

endpackage

/* sv/gap_buffer_text_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Gap buffer of CAPACITY text bytes held in one synchronous memory.
// ----------------------------------------------------------------------------
// Insert, delete and any rejected command give their result beat in the cycle
// after start; a read passes through the memory's read register and then the
// output register; a cursor move over a distance d copies one byte per cycle
// through the memory's single read port. busy is high while a read or move is in flight.
// Reset clears state, cursor and gap; the memory is not cleared. out_valid
// lasts one cycle and the receiver cannot stall it.
module gap_buffer_text_store #(
  parameter int CAPACITY = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  gbts_pkg::kind_t             in_kind,
  input  gbts_pkg::char_t             in_char_in,
  input  logic [gbts_pkg::POS_W-1:0]  in_position,
  output logic                        out_valid,
  output gbts_pkg::char_t             out_char_out,
  output logic [gbts_pkg::POS_W-1:0]  out_cursor,
  output logic [gbts_pkg::POS_W-1:0]  out_text_length,
  output gbts_pkg::status_t           out_status
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int CW = (PW > gbts_pkg::POS_W) ? PW : gbts_pkg::POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOVE = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [PW-1:0]     gs_r, gs_nxt;
  logic [PW-1:0]     ge_r, ge_nxt;
  logic [PW-1:0]     tgt_r, tgt_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  gbts_pkg::char_t   out_char_r, out_char_nxt;
  gbts_pkg::status_t out_status_r, out_status_nxt;

  gbts_pkg::char_t   text_mem [CAPACITY];
  gbts_pkg::char_t   rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  gbts_pkg::char_t   mem_wdata;
  logic [AW-1:0]     mem_raddr;

  logic              accept;
  logic [PW-1:0]     gap;
  logic [PW-1:0]     len;
  logic [CW-1:0]     pos_ext;
  logic [CW-1:0]     len_ext;
  logic [CW-1:0]     gs_ext;
  logic [CW-1:0]     phys_ext;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign gap     = ge_r - gs_r;
  assign len     = PW'(CAPACITY) - gap;
  assign pos_ext = CW'(in_position);
  assign len_ext = CW'(len);
  assign gs_ext  = CW'(gs_r);
  assign phys_ext = (pos_ext < gs_ext) ? pos_ext : pos_ext + CW'(gap);

  always_comb begin
    state_nxt      = state_r;
    gs_nxt         = gs_r;
    ge_nxt         = ge_r;
    tgt_nxt        = tgt_r;
    wr_pend_nxt    = 1'b0;
    wr_addr_nxt    = wr_addr_r;
    out_valid_nxt  = 1'b0;
    out_char_nxt   = out_char_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = '0;

    // finish the copy whose byte was read last cycle
    if (wr_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_r;
      mem_wdata = rd_data_r;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_char_nxt   = '0;
          out_status_nxt = gbts_pkg::ST_OK;
          case (in_kind)
            gbts_pkg::KIND_INSERT: begin
              out_valid_nxt = 1'b1;
              if (gs_r == ge_r) begin
                out_status_nxt = gbts_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(gs_r);
                mem_wdata = in_char_in;
                gs_nxt    = gs_r + 1'b1;
              end
            end
            gbts_pkg::KIND_DELETE: begin
              out_valid_nxt = 1'b1;
              if (gs_r == '0) begin
                out_status_nxt = gbts_pkg::ST_EMPTY;
              end else begin
                gs_nxt = gs_r - 1'b1;
              end
            end
            gbts_pkg::KIND_MOVE: begin
              if (pos_ext > len_ext) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = gbts_pkg::ST_RANGE;
              end else begin
                tgt_nxt   = PW'(in_position);
                state_nxt = S_MOVE;
              end
            end
            gbts_pkg::KIND_READ: begin
              if (pos_ext >= len_ext) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = gbts_pkg::ST_RANGE;
              end else begin
                mem_raddr = AW'(phys_ext);
                state_nxt = S_READ;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_MOVE: begin
        if (gs_r == tgt_r) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = '0;
          out_status_nxt = gbts_pkg::ST_OK;
          state_nxt      = S_IDLE;
        end else if (tgt_r < gs_r) begin
          // slide one byte from below the gap to its top end
          mem_raddr   = AW'(gs_r - 1'b1);
          wr_addr_nxt = AW'(ge_r - 1'b1);
          wr_pend_nxt = 1'b1;
          gs_nxt      = gs_r - 1'b1;
          ge_nxt      = ge_r - 1'b1;
        end else begin
          // slide one byte from above the gap to its bottom end
          mem_raddr   = AW'(ge_r);
          wr_addr_nxt = AW'(gs_r);
          wr_pend_nxt = 1'b1;
          gs_nxt      = gs_r + 1'b1;
          ge_nxt      = ge_r + 1'b1;
        end
      end
      S_READ: begin
        out_valid_nxt  = 1'b1;
        out_char_nxt   = rd_data_r;
        out_status_nxt = gbts_pkg::ST_OK;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gs_r        <= '0;
      ge_r        <= PW'(CAPACITY);
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gs_r        <= gs_nxt;
      ge_r        <= ge_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r        <= tgt_nxt;
    wr_addr_r    <= wr_addr_nxt;
    out_char_r   <= out_char_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= text_mem[mem_raddr];
  end

  logic [CW-1:0] cursor_ext;
  assign cursor_ext = gs_ext;

  assign out_valid       = out_valid_r;
  assign out_char_out    = out_char_r;
  assign out_cursor      = cursor_ext[gbts_pkg::POS_W-1:0];
  assign out_text_length = len_ext[gbts_pkg::POS_W-1:0];
  assign out_status      = out_status_r;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert, delete, move and read commands into the gap buffer text
// store and checks every result beat against a shadow copy of the text.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TEXT_CAP     = 256;
  localparam int RANDOM_EDITS = 1450;
  localparam int QUIET_LIMIT  = 2000;

  typedef logic [gbts_pkg::POS_W-1:0] pos_t;

  typedef struct {
    gbts_pkg::char_t   ch;
    pos_t              cursor;
    pos_t              length;
    gbts_pkg::status_t status;
  } edit_result_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} edit_mode_t;

  class text_scoreboard_t;
    gbts_pkg::char_t shadow_text[$];
    int unsigned     shadow_cursor;
    edit_result_t    results_due[$];
    int unsigned     errors;
    int unsigned     beats_checked;
    int unsigned     peak_length;
    int unsigned     kind_seen[4];
    int unsigned     status_seen[4];

    function new();
      shadow_cursor = 0;
      errors        = 0;
      beats_checked = 0;
      peak_length   = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned text_length();
      return shadow_text.size();
    endfunction

    function int unsigned results_pending();
      return results_due.size();
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      errors++;
    endtask

    // Apply one accepted command to the shadow text and queue its result.
    task note_edit(input gbts_pkg::kind_t kind, input gbts_pkg::char_t ch,
                   input pos_t pos);
      edit_result_t res;
      int unsigned  len;
      len        = shadow_text.size();
      res.ch     = '0;
      res.status = gbts_pkg::ST_OK;
      case (kind)
        gbts_pkg::KIND_INSERT: begin
          if (len >= TEXT_CAP) begin
            res.status = gbts_pkg::ST_FULL;
          end else begin
            shadow_text.insert(shadow_cursor, ch);
            shadow_cursor++;
          end
        end
        gbts_pkg::KIND_DELETE: begin
          if (shadow_cursor == 0) begin
            res.status = gbts_pkg::ST_EMPTY;
          end else begin
            shadow_text.delete(shadow_cursor - 1);
            shadow_cursor--;
          end
        end
        gbts_pkg::KIND_MOVE: begin
          if (pos > len) res.status = gbts_pkg::ST_RANGE;
          else shadow_cursor = pos;
        end
        default: begin
          if (pos >= len) res.status = gbts_pkg::ST_RANGE;
          else res.ch = shadow_text[pos];
        end
      endcase
      res.cursor = pos_t'(shadow_cursor);
      res.length = pos_t'(shadow_text.size());
      if (shadow_text.size() > peak_length) peak_length = shadow_text.size();
      kind_seen[kind]++;
      status_seen[res.status]++;
      results_due.push_back(res);
    endtask

    task check_beat(input gbts_pkg::char_t ch, input pos_t cursor, input pos_t length,
                    input gbts_pkg::status_t status);
      edit_result_t exp;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing outstanding (cursor %0d)",
                                  cursor));
      end else begin
        exp = results_due.pop_front();
        beats_checked++;
        if (ch !== exp.ch)
          report_mismatch($sformatf("char_out %0h, want %0h", ch, exp.ch));
        if (cursor !== exp.cursor)
          report_mismatch($sformatf("cursor %0d, want %0d", cursor, exp.cursor));
        if (length !== exp.length)
          report_mismatch($sformatf("text_length %0d, want %0d", length, exp.length));
        if (status !== exp.status)
          report_mismatch($sformatf("status %0d, want %0d", status, exp.status));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  gbts_pkg::kind_t   in_kind;
  gbts_pkg::char_t   in_char_in;
  pos_t              in_position;
  logic              out_valid;
  gbts_pkg::char_t   out_char_out;
  pos_t              out_cursor;
  pos_t              out_text_length;
  gbts_pkg::status_t out_status;

  text_scoreboard_t sb;
  int               quiet_cycles;
  int               idle_pct;

  gap_buffer_text_store #(
    .CAPACITY(TEXT_CAP)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_char_in     (in_char_in),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_char_out   (out_char_out),
    .out_cursor     (out_cursor),
    .out_text_length(out_text_length),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_beat(out_char_out, out_cursor, out_text_length, out_status);
  end

  // End the run if neither a command nor a result beat moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Call just after a rising edge; returns at the edge that accepts the beat.
  task automatic send_command(input gbts_pkg::kind_t kind, input gbts_pkg::char_t ch,
                              input pos_t pos);
    start       <= 1'b1;
    in_kind     <= kind;
    in_char_in  <= ch;
    in_position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_edit(kind, ch, pos);
  endtask

  task automatic sender_idle(input int pct);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
      gap++;
    end
  endtask

  // Hold off until every outstanding result has come back.
  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.results_pending() != 0);
  endtask

  function automatic pos_t pick_position(input int len, input bit for_read);
    int r;
    int top;
    r   = $urandom_range(0, 99);
    top = for_read ? len - 1 : len;
    if (r < 70 && top >= 0) return pos_t'($urandom_range(0, top));
    if (r < 80) return pos_t'(len);
    if (r < 90) return pos_t'(len + $urandom_range(1, 2));
    return pos_t'($urandom_range(0, 511));
  endfunction

  task automatic random_edit(input edit_mode_t mode);
    int              r;
    int              len;
    gbts_pkg::kind_t kind;
    gbts_pkg::char_t ch;
    pos_t            pos;
    len = sb.text_length();
    r   = $urandom_range(0, 99);
    ch  = gbts_pkg::char_t'($urandom_range(0, 255));
    case (mode)
      MODE_FILL: begin
        kind = (r < 80) ? gbts_pkg::KIND_INSERT : (r < 85) ? gbts_pkg::KIND_DELETE :
               (r < 93) ? gbts_pkg::KIND_MOVE : gbts_pkg::KIND_READ;
      end
      MODE_DRAIN: begin
        kind = (r < 75) ? gbts_pkg::KIND_DELETE : (r < 80) ? gbts_pkg::KIND_INSERT :
               (r < 92) ? gbts_pkg::KIND_MOVE : gbts_pkg::KIND_READ;
      end
      default: begin
        kind = (r < 35) ? gbts_pkg::KIND_INSERT : (r < 60) ? gbts_pkg::KIND_DELETE :
               (r < 80) ? gbts_pkg::KIND_MOVE : gbts_pkg::KIND_READ;
      end
    endcase
    if (kind == gbts_pkg::KIND_READ)
      pos = pick_position(len, 1'b1);
    else if (kind == gbts_pkg::KIND_MOVE && mode == MODE_DRAIN &&
             $urandom_range(0, 9) < 7)
      pos = pos_t'(len);  // park at the end so deletes keep biting
    else if (kind == gbts_pkg::KIND_MOVE)
      pos = pick_position(len, 1'b0);
    else
      pos = pos_t'($urandom_range(0, 511));
    send_command(kind, ch, pos);
  endtask

  initial begin
    edit_mode_t mode;
    edit_mode_t next_after_mixed;
    int         mode_count;
    sb           = new();
    quiet_cycles = 0;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_kind     <= gbts_pkg::KIND_INSERT;
    in_char_in  <= '0;
    in_position <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty buffer, boundaries, same-place move, middle insert.
    send_command(gbts_pkg::KIND_DELETE, 8'h00, 9'd0);
    send_command(gbts_pkg::KIND_READ,   8'h00, 9'd0);
    send_command(gbts_pkg::KIND_MOVE,   8'h00, 9'd0);
    send_command(gbts_pkg::KIND_MOVE,   8'h00, 9'd1);
    send_command(gbts_pkg::KIND_MOVE,   8'hFF, 9'd511);
    send_command(gbts_pkg::KIND_INSERT, 8'h00, 9'd0);
    send_command(gbts_pkg::KIND_INSERT, 8'hFF, 9'd511);
    send_command(gbts_pkg::KIND_INSERT, 8'hA5, 9'd256);
    send_command(gbts_pkg::KIND_READ,   8'h00, 9'd0);
    send_command(gbts_pkg::KIND_READ,   8'h00, 9'd2);
    send_command(gbts_pkg::KIND_READ,   8'h00, 9'd3);
    send_command(gbts_pkg::KIND_READ,   8'h00, 9'd256);
    send_command(gbts_pkg::KIND_MOVE,   8'h00, 9'd1);
    send_command(gbts_pkg::KIND_MOVE,   8'h00, 9'd1);
    send_command(gbts_pkg::KIND_INSERT, 8'h5A, 9'd0);
    send_command(gbts_pkg::KIND_READ,   8'h00, 9'd1);
    send_command(gbts_pkg::KIND_MOVE,   8'h00, 9'd4);
    send_command(gbts_pkg::KIND_MOVE,   8'h00, 9'd0);
    send_command(gbts_pkg::KIND_DELETE, 8'h00, 9'd0);
    send_command(gbts_pkg::KIND_MOVE,   8'h00, 9'd2);
    send_command(gbts_pkg::KIND_DELETE, 8'h00, 9'd0);
    send_command(gbts_pkg::KIND_READ,   8'h00, 9'd1);
    send_command(gbts_pkg::KIND_MOVE,   8'h00, 9'd3);
    send_command(gbts_pkg::KIND_INSERT, 8'h3C, 9'd511);

    // Random: alternate fill-to-full and drain-to-empty with mixed stretches.
    idle_pct         = 12;
    mode             = MODE_FILL;
    next_after_mixed = MODE_DRAIN;
    mode_count       = 0;
    for (int n = 0; n < RANDOM_EDITS; n++) begin
      if (n == RANDOM_EDITS / 3) begin
        wait_all_results();
        idle_pct = 60;
      end else if (n == 2 * RANDOM_EDITS / 3) begin
        wait_all_results();
        idle_pct = 0;
      end
      sender_idle(idle_pct);
      random_edit(mode);
      case (mode)
        MODE_FILL:  if (sb.text_length() == TEXT_CAP) mode_count++;
        MODE_DRAIN: if (sb.text_length() == 0) mode_count++;
        default:    mode_count++;
      endcase
      if ((mode != MODE_MIXED && mode_count > 3) ||
          (mode == MODE_MIXED && mode_count >= 150)) begin
        mode_count = 0;
        if (mode == MODE_MIXED) begin
          mode             = next_after_mixed;
          next_after_mixed = (mode == MODE_FILL) ? MODE_DRAIN : MODE_FILL;
        end else begin
          mode = MODE_MIXED;
        end
      end
    end

    wait_all_results();
    repeat (8) @(posedge clk);

    $display("Covered %0d commands (insert %0d, delete %0d, move %0d, read %0d), %0d %s",
             sb.kind_seen[gbts_pkg::KIND_INSERT] + sb.kind_seen[gbts_pkg::KIND_DELETE] +
             sb.kind_seen[gbts_pkg::KIND_MOVE] + sb.kind_seen[gbts_pkg::KIND_READ],
             sb.kind_seen[gbts_pkg::KIND_INSERT], sb.kind_seen[gbts_pkg::KIND_DELETE],
             sb.kind_seen[gbts_pkg::KIND_MOVE], sb.kind_seen[gbts_pkg::KIND_READ],
             sb.beats_checked, "beats checked");
    $display("Status mix: ok %0d, full %0d, empty %0d, range %0d; peak length %0d",
             sb.status_seen[gbts_pkg::ST_OK], sb.status_seen[gbts_pkg::ST_FULL],
             sb.status_seen[gbts_pkg::ST_EMPTY], sb.status_seen[gbts_pkg::ST_RANGE],
             sb.peak_length);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
